// File: rtl/sfr_pkg.sv
package sfr_pkg;

    localparam int unsigned LENGTH_WIDTH_DEF = 16;
    localparam int unsigned CFG_WIDTH        = 16;
    localparam int unsigned OUT_LEN_WIDTH    = 16;
    localparam int unsigned FIFO_DEPTH       = 8;
    localparam int unsigned FIFO_PTR_WIDTH   = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_WIDTH   = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_WIDTH-1:0] MIN_FRAME_RESET = 16'd20;
    localparam logic [CFG_WIDTH-1:0] MAX_FRAME_RESET = 16'd1499;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic REG_MIN_FRAME = 1'b0;
    localparam logic REG_MAX_FRAME = 1'b1;

    typedef enum logic [2:0] {
        EV_DATA     = 3'd0,
        EV_ACCEPT   = 3'd1,
        EV_SHORT    = 3'd2,
        EV_BADESC   = 3'd3,
        EV_OVERSIZE = 3'd4
    } t_event;

    typedef struct packed {
        t_event                   ev;
        logic [7:0]               data;
        logic [OUT_LEN_WIDTH-1:0] len;
        logic                     last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

endpackage

// File: rtl/slip_frame_receiver_top.sv
// channel   | handshake                  | payload
// rx        | i_rx_valid / o_rx_ready    | i_rx_byte
// result    | o_res_valid / i_res_ready  | o_event_res, o_data_byte, o_frame_length, o_last
// config    | psel, penable, pwrite      | paddr, pwdata, prdata
//
// one rx byte per cycle while o_rx_ready is high; it is decoded the cycle after its transfer
// and its zero to two results are queued in an eight-entry result fifo
// first result shows on the port once the byte has passed the input register and been written to the fifo
// rx stalls while the fifo lacks room for two results each for the byte in decode and a new one
// synchronous active-low reset clears the frame state, fifo and registers
module slip_frame_receiver_top
    import sfr_pkg::*;
#(
    parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rx_valid,
    output logic                     o_rx_ready,
    input  logic [7:0]               i_rx_byte,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output logic [2:0]               o_event_res,
    output logic [7:0]               o_data_byte,
    output logic [OUT_LEN_WIDTH-1:0] o_frame_length,
    output logic                     o_last,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [CFG_WIDTH-1:0] r_min;
    logic [CFG_WIDTH-1:0] r_max;
    logic                 reg_sel;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    t_dec_out   dec;

    t_result                   r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_WIDTH-1:0] r_wr_ptr;
    logic [FIFO_PTR_WIDTH-1:0] r_rd_ptr;
    logic [FIFO_CNT_WIDTH-1:0] r_count;
    logic [FIFO_CNT_WIDTH-1:0] occ;
    logic                      pop;
    t_result                   head;

    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign prdata  = (reg_sel == REG_MAX_FRAME) ? {16'd0, r_max} : {16'd0, r_min};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_FRAME_RESET;
            r_max <= MAX_FRAME_RESET;
        end else if (psel && penable && pwrite) begin
            if (reg_sel == REG_MIN_FRAME) begin
                r_min <= pwdata[CFG_WIDTH-1:0];
            end else begin
                r_max <= pwdata[CFG_WIDTH-1:0];
            end
        end
    end

    // room for the pending byte and a new one, two results each
    assign occ        = r_count + (r_in_vld ? FIFO_CNT_WIDTH'(2) : FIFO_CNT_WIDTH'(0));
    assign o_rx_ready = occ <= FIFO_CNT_WIDTH'(FIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_rx_valid && o_rx_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sfr_decode #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_decode (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_in_vld),
        .i_byte (r_in_byte),
        .i_min  (r_min),
        .i_max  (r_max),
        .o_dec  (dec)
    );

    assign head           = r_fifo[r_rd_ptr];
    assign o_res_valid    = r_count != '0;
    assign pop            = o_res_valid && i_res_ready;
    assign o_event_res    = head.ev;
    assign o_data_byte    = head.data;
    assign o_frame_length = head.len;
    assign o_last         = head.last;

    always_ff @(posedge i_clk) begin
        if (dec.num != 2'd0) begin
            r_fifo[r_wr_ptr] <= dec.res0;
        end
        if (dec.num == 2'd2) begin
            r_fifo[r_wr_ptr + 1'b1] <= dec.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_WIDTH'(dec.num);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FIFO_CNT_WIDTH'(dec.num) - FIFO_CNT_WIDTH'(pop);
        end
    end

endmodule

// File: rtl/sfr_decode.sv
module sfr_decode
    import sfr_pkg::*;
#(
    parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [7:0]           i_byte,
    input  logic [CFG_WIDTH-1:0] i_min,
    input  logic [CFG_WIDTH-1:0] i_max,
    output t_dec_out             o_dec
);

    localparam int unsigned CMP_WIDTH = (LENGTH_WIDTH > CFG_WIDTH) ? LENGTH_WIDTH : CFG_WIDTH;
    localparam logic [LENGTH_WIDTH-1:0] CNT_MAX = '1;

    logic                    r_esc;
    logic [LENGTH_WIDTH-1:0] r_cnt;
    logic                    n_esc;
    logic [LENGTH_WIDTH-1:0] n_cnt;

    logic                    over;
    logic [LENGTH_WIDTH-1:0] cnt0;
    logic [LENGTH_WIDTH-1:0] bumped;
    logic                    has;
    t_result                 over_res;
    t_result                 byte_res;

    always_comb begin
        over   = CMP_WIDTH'(r_cnt) >= CMP_WIDTH'(i_max);
        cnt0   = over ? '0 : r_cnt;
        bumped = (cnt0 == CNT_MAX) ? cnt0 : cnt0 + 1'b1;

        over_res = '{ev: EV_OVERSIZE, data: 8'd0, len: OUT_LEN_WIDTH'(r_cnt), last: 1'b0};
        byte_res = '{ev: EV_DATA, data: 8'd0, len: '0, last: 1'b1};
        has      = 1'b1;
        n_esc    = r_esc;
        n_cnt    = cnt0;

        if (r_esc) begin
            n_esc = 1'b0;
            if (i_byte == SLIP_ESC_END || i_byte == SLIP_ESC_ESC) begin
                n_cnt         = bumped;
                byte_res.data = (i_byte == SLIP_ESC_END) ? SLIP_END : SLIP_ESC;
                byte_res.len  = OUT_LEN_WIDTH'(bumped);
            end else begin
                n_cnt        = '0;
                byte_res.ev  = EV_BADESC;
                byte_res.len = OUT_LEN_WIDTH'(cnt0);
            end
        end else if (i_byte == SLIP_ESC) begin
            n_esc = 1'b1;
            has   = 1'b0;
        end else if (i_byte == SLIP_END) begin
            n_cnt        = '0;
            byte_res.ev  = (CMP_WIDTH'(cnt0) < CMP_WIDTH'(i_min)) ? EV_SHORT : EV_ACCEPT;
            byte_res.len = OUT_LEN_WIDTH'(cnt0);
        end else begin
            n_cnt         = bumped;
            byte_res.data = i_byte;
            byte_res.len  = OUT_LEN_WIDTH'(bumped);
        end

        // oversize drop goes first, the byte's own result after it
        if (over) begin
            over_res.last = !has;
            o_dec.num     = has ? 2'd2 : 2'd1;
            o_dec.res0    = over_res;
            o_dec.res1    = byte_res;
        end else begin
            o_dec.num  = has ? 2'd1 : 2'd0;
            o_dec.res0 = byte_res;
            o_dec.res1 = over_res;
        end

        if (!i_vld) begin
            o_dec.num = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
            r_cnt <= '0;
        end else if (i_vld) begin
            r_esc <= n_esc;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: rtl/sfr_checker.sv
module sfr_checker
    import sfr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_res_valid,
    input logic       i_res_ready,
    input logic [2:0] o_event_res,
    input logic [7:0] o_data_byte,
    input logic       o_last,
    input logic       pready
);

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_event_res <= EV_OVERSIZE)
        else $error("event code out of range");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_event_res != EV_DATA |-> o_data_byte == 8'd0)
        else $error("data byte set on a frame event");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_event_res)
            && $stable(o_data_byte) && $stable(o_last))
        else $error("stalled result changed");

endmodule

bind slip_frame_receiver_top sfr_checker u_sfr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_res_valid(o_res_valid),
    .i_res_ready(i_res_ready),
    .o_event_res(o_event_res),
    .o_data_byte(o_data_byte),
    .o_last     (o_last),
    .pready     (pready)
);

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 190;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_rx_valid;
    logic                     o_rx_ready;
    logic [7:0]               i_rx_byte;
    logic                     o_res_valid;
    logic                     i_res_ready;
    logic [2:0]               o_event_res;
    logic [7:0]               o_data_byte;
    logic [OUT_LEN_WIDTH-1:0] o_frame_length;
    logic                     o_last;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [2:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    // decoder state mirrored on the testbench side
    logic                        esc_pending_m;
    logic [LENGTH_WIDTH_DEF-1:0] frame_cnt_m;
    logic [CFG_WIDTH-1:0]        min_bytes_m;
    logic [CFG_WIDTH-1:0]        max_bytes_m;

    t_result expected_slip_events[$];

    int  fail_count      = 0;
    int  results_checked = 0;
    int  rx_bytes_sent   = 0;
    int  settings_used   = 0;
    int  cycle_cnt       = 0;
    int  hold_off_req    = 0;
    bit  rx_steady       = 1'b0;
    bit  sink_steady     = 1'b0;

    slip_frame_receiver_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_event_res    (o_event_res),
        .o_data_byte    (o_data_byte),
        .o_frame_length (o_frame_length),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return SLIP_END;
        if (r < 45) return SLIP_ESC;
        if (r < 55) return SLIP_ESC_END;
        if (r < 65) return SLIP_ESC_ESC;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void queue_event(input t_event ev, input logic [7:0] data,
                                        input logic [LENGTH_WIDTH_DEF-1:0] len);
        t_result r;
        r.ev   = ev;
        r.data = data;
        r.len  = OUT_LEN_WIDTH'(len);
        r.last = 1'b0;
        expected_slip_events.push_back(r);
    endfunction

    function automatic void count_byte();
        if (frame_cnt_m != '1) frame_cnt_m++;
    endfunction

    function automatic void decode_rx_byte(input logic [7:0] b);
        int n;
        n = 0;
        if (frame_cnt_m >= max_bytes_m) begin
            queue_event(EV_OVERSIZE, 8'h00, frame_cnt_m);
            frame_cnt_m = '0;
            n++;
        end
        if (esc_pending_m) begin
            esc_pending_m = 1'b0;
            if (b == SLIP_ESC_END || b == SLIP_ESC_ESC) begin
                count_byte();
                queue_event(EV_DATA, (b == SLIP_ESC_END) ? SLIP_END : SLIP_ESC, frame_cnt_m);
            end else begin
                queue_event(EV_BADESC, 8'h00, frame_cnt_m);
                frame_cnt_m = '0;
            end
            n++;
        end else if (b == SLIP_ESC) begin
            esc_pending_m = 1'b1;
        end else if (b == SLIP_END) begin
            queue_event((frame_cnt_m < min_bytes_m) ? EV_SHORT : EV_ACCEPT, 8'h00, frame_cnt_m);
            frame_cnt_m = '0;
            n++;
        end else begin
            count_byte();
            queue_event(EV_DATA, b, frame_cnt_m);
            n++;
        end
        if (n > 0) expected_slip_events[expected_slip_events.size()-1].last = 1'b1;
    endfunction

    // result port: random stalls plus an optional long hold-off
    initial begin : res_sink
        int stall_left;
        stall_left = 0;
        i_res_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req > 0) begin
                stall_left   = hold_off_req;
                hold_off_req = 0;
            end else if (stall_left == 0 && !sink_steady) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_res_ready <= 1'b0;
                stall_left--;
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : res_check
        t_result exp_res;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (expected_slip_events.size() == 0) begin
                $error("unexpected result: event_res %0d, frame_length %0d",
                       o_event_res, o_frame_length);
                fail_count++;
            end else begin
                exp_res = expected_slip_events.pop_front();
                results_checked++;
                if (o_event_res !== exp_res.ev) begin
                    $error("event_res mismatch: expected %0d, got %0d", exp_res.ev, o_event_res);
                    fail_count++;
                end
                if (o_data_byte !== exp_res.data) begin
                    $error("data_byte mismatch: expected 0x%02h, got 0x%02h",
                           exp_res.data, o_data_byte);
                    fail_count++;
                end
                if (o_frame_length !== exp_res.len) begin
                    $error("frame_length mismatch: expected %0d, got %0d",
                           exp_res.len, o_frame_length);
                    fail_count++;
                end
                if (o_last !== exp_res.last) begin
                    $error("last mismatch: expected %0d, got %0d", exp_res.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        decode_rx_byte(b);
        rx_bytes_sent++;
        gap = rx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic finish_phase();
        i_rx_valid <= 1'b0;
        while (expected_slip_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MIN_FRAME) min_bytes_m = value[CFG_WIDTH-1:0];
        else max_bytes_m = value[CFG_WIDTH-1:0];
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic idx, input logic [CFG_WIDTH-1:0] want);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[CFG_WIDTH-1:0] !== want) begin
            $error("register %0d readback mismatch: expected %0d, got %0d",
                   idx, want, rd[CFG_WIDTH-1:0]);
            fail_count++;
        end
        @(posedge i_clk);
    endtask

    task automatic set_frame_limits(input logic [CFG_WIDTH-1:0] min_val,
                                    input logic [CFG_WIDTH-1:0] max_val);
        // upper bits are random and must be dropped by the block
        write_reg(REG_MIN_FRAME, {16'($urandom), min_val});
        write_reg(REG_MAX_FRAME, {16'($urandom), max_val});
        check_reg(REG_MIN_FRAME, min_val);
        check_reg(REG_MAX_FRAME, max_val);
        settings_used++;
    endtask

    task automatic send_random_stream(input int budget);
        int         start_cnt;
        int         len;
        int         r;
        int         mn;
        int         mx;
        logic [7:0] b;
        start_cnt = rx_bytes_sent;
        while (rx_bytes_sent - start_cnt < budget) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                mn = int'(min_bytes_m);
                mx = int'(max_bytes_m);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: len = $urandom_range(0, 8);
                    4, 5, 6:    len = (mn > 57) ? $urandom_range(0, 60)
                                                : $urandom_range((mn < 3) ? 0 : mn - 3, mn + 3);
                    7, 8:       len = (mx > 57) ? $urandom_range(0, 60)
                                                : $urandom_range((mx < 3) ? 0 : mx - 3, mx + 3);
                    default:    len = $urandom_range(0, 60);
                endcase
                repeat (len) begin
                    r = $urandom_range(0, 99);
                    if (r < 8) b = SLIP_END;
                    else if (r < 15) b = SLIP_ESC;
                    else if (r < 18) b = SLIP_ESC_END;
                    else if (r < 21) b = SLIP_ESC_ESC;
                    else b = 8'($urandom_range(0, 255));
                    if (b == SLIP_END) begin
                        send_rx_byte(SLIP_ESC);
                        send_rx_byte(SLIP_ESC_END);
                    end else if (b == SLIP_ESC) begin
                        send_rx_byte(SLIP_ESC);
                        send_rx_byte(SLIP_ESC_ESC);
                    end else begin
                        send_rx_byte(b);
                    end
                end
                send_rx_byte(SLIP_END);
            end else if (r < 90) begin
                // escape followed by anything, often a bad one
                send_rx_byte(SLIP_ESC);
                send_rx_byte(pick_noise());
            end else begin
                send_rx_byte(pick_noise());
            end
        end
    endtask

    task automatic test_reset_values();
        check_reg(REG_MIN_FRAME, MIN_FRAME_RESET);
        check_reg(REG_MAX_FRAME, MAX_FRAME_RESET);
    endtask

    task automatic test_directed_cases();
        logic [7:0] seq[$] = '{
            SLIP_END,
            8'h00, 8'hFF, SLIP_END,
            SLIP_ESC, SLIP_ESC_END, SLIP_ESC, SLIP_ESC_ESC, 8'h7F,
            SLIP_ESC, 8'h41,
            SLIP_ESC, SLIP_END,
            8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
            SLIP_ESC_END, 8'h07, 8'h08, SLIP_ESC, SLIP_ESC_END,
            SLIP_END
        };
        rx_steady = 1'b0;
        set_frame_limits(16'd2, 16'd4);
        foreach (seq[i]) send_rx_byte(seq[i]);
        finish_phase();
    endtask

    task automatic test_tiny_max();
        logic [7:0] seq[$] = '{8'h41, SLIP_END, SLIP_ESC, SLIP_ESC_END, SLIP_END, 8'h80};
        set_frame_limits(16'd0, 16'd0);
        foreach (seq[i]) send_rx_byte(seq[i]);
        finish_phase();
        set_frame_limits(16'd0, 16'd1);
        foreach (seq[i]) send_rx_byte(seq[i]);
        finish_phase();
    endtask

    task automatic test_random_settings();
        logic [CFG_WIDTH-1:0] mins[$] = '{16'd20, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
        logic [CFG_WIDTH-1:0] maxs[$] = '{16'd1499, 16'd2, 16'hFFFF, 16'hFFFF, 16'd2};
        repeat (3) begin
            mins.push_back(CFG_WIDTH'($urandom_range(0, 30)));
            maxs.push_back(CFG_WIDTH'($urandom_range(2, 64)));
        end
        foreach (mins[i]) begin
            rx_steady   = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            set_frame_limits(mins[i], maxs[i]);
            send_random_stream(PHASE_BYTES);
            finish_phase();
        end
        rx_steady   = 1'b0;
        sink_steady = 1'b0;
    endtask

    task automatic test_fill_and_stall();
        set_frame_limits(16'd4, 16'd24);
        rx_steady    = 1'b1;
        hold_off_req = 300;
        send_random_stream(60);
        rx_steady = 1'b0;
        finish_phase();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_rx_valid <= 1'b0;
        i_rx_byte  <= 8'h00;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        esc_pending_m = 1'b0;
        frame_cnt_m   = '0;
        min_bytes_m   = MIN_FRAME_RESET;
        max_bytes_m   = MAX_FRAME_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed_cases();
        test_tiny_max();
        test_random_settings();
        test_fill_and_stall();

        $display("covered %0d rx bytes under %0d frame limit settings (zero and full-scale too)",
                 rx_bytes_sent, settings_used);
        $display("compared %0d results, including a long result hold-off with rx backed up",
                 results_checked);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
